>>> hw/rtl/tla_pkg.sv
package tla_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int ROW_AW      = $clog2(MAX_ROWS);
    localparam int SIZE_W      = 7;
    localparam int CHG_W       = 13;
    localparam int POP_W       = $clog2(MAX_COLUMNS + 1);

    typedef logic [MAX_COLUMNS-1:0] t_row;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_ROWS    = 1'b0,
        CFG_COLUMNS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_G0,
        ST_G1,
        ST_SWEEP,
        ST_TAIL,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [5:0] column;
        logic       alive_in;
    } t_req;

    typedef struct packed {
        logic             alive_out;
        logic [CHG_W-1:0] changed_cells;
        logic             bad_position;
    } t_rsp;

    // 0 reads as 1, anything above the maximum clamps to it
    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v,
                                                  logic [SIZE_W-1:0] maxv);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    // one generation of row c, given the rows above and below (all old values)
    function automatic t_row life_row(t_row p, t_row c, t_row n,
                                      logic [SIZE_W-1:0] nc);
        t_row     res;
        int       li;
        int       ri;
        logic [3:0] sum;
        res = c;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            if (i < int'(nc)) begin
                li  = (i == 0) ? int'(nc) - 1 : i - 1;
                ri  = (i == int'(nc) - 1) ? 0 : i + 1;
                sum = 4'(p[li]) + 4'(p[i]) + 4'(p[ri]) + 4'(c[li]) + 4'(c[ri])
                    + 4'(n[li]) + 4'(n[i]) + 4'(n[ri]);
                res[i] = (sum == 4'd3) | (c[i] & (sum == 4'd2));
            end
        end
        return res;
    endfunction

    function automatic logic [POP_W-1:0] pop_row(t_row v);
        logic [POP_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            cnt = cnt + POP_W'(v[i]);
        end
        return cnt;
    endfunction

endpackage

>>> hw/rtl/tla_ram.sv
module tla_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/toroidal_life_automaton.sv
// Channel   | direction | handshake                    | payload
// request   | in        | i_valid / o_ready            | i_req (kind, row, column, alive_in)
// response  | out       | o_valid / i_ready            | o_rsp (alive_out, changed_cells,
//           |           |                              |        bad_position)
// config    | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Steps: a cell write or read passes RAM read, modify/write and staging before the response
// register; a bad position or unused kind goes straight to staging.
// A generation reads the last row and row 0, then sweeps the rows in use: the grid RAM gives
// one row word per cycle, each written back once.
// Reset: synchronous, active low; a valid bit per row makes an unwritten row read all dead.
// Stalls: requests are taken only when idle; a held response keeps the next in staging.
module toroidal_life_automaton
    import tla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rsp              o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    // control
    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_rows_cfg, n_rows_cfg;
    logic [SIZE_W-1:0]   r_cols_cfg, n_cols_cfg;
    logic [MAX_ROWS-1:0] r_vld, n_vld;       // row has been written since reset
    logic                r_rvld, n_rvld;     // valid bit of the row in flight from RAM
    logic                r_out_vld, n_out_vld;
    logic [SIZE_W-1:0]   r_rd, n_rd;         // next row to read during a sweep
    logic [SIZE_W-1:0]   r_k, n_k;           // row whose word arrives this cycle
    logic                r_chg_v, n_chg_v;

    // data
    t_req                r_req, n_req;
    t_row                r_prev, n_prev;     // old row above the one being updated
    t_row                r_cur, n_cur;       // old row being updated
    t_row                r_row0, n_row0;     // old row 0, wraps in below the last row
    t_row                r_chg, n_chg;       // toggled cells of the last updated row
    logic [CHG_W-1:0]    r_sum, n_sum;
    t_rsp                r_res, n_res;
    t_rsp                r_out, n_out;

    // grid RAM port
    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    t_row                ram_wdata;
    logic [ROW_AW-1:0]   ram_raddr;
    t_row                ram_q;

    logic [SIZE_W-1:0]   nr;
    logic [SIZE_W-1:0]   nc;
    t_row                rd_row;
    t_row                nxt_row;
    t_row                new_row;
    logic                bad;

    tla_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign nr = eff_size(r_rows_cfg, SIZE_W'(MAX_ROWS));
    assign nc = eff_size(r_cols_cfg, SIZE_W'(MAX_COLUMNS));

    // never-written rows read as dead
    assign rd_row = r_rvld ? ram_q : '0;

    // window: the row after the last one is the saved old row 0
    assign nxt_row = (r_k == nr) ? r_row0 : rd_row;
    assign new_row = life_row(r_prev, r_cur, nxt_row, nc);

    assign bad = ({1'b0, i_req.row} >= nr) || ({1'b0, i_req.column} >= nc);

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_vld;
    assign o_rsp       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rows_cfg <= SIZE_W'(MAX_ROWS);
            r_cols_cfg <= SIZE_W'(MAX_COLUMNS);
            r_vld      <= '0;
            r_rvld     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_rd       <= '0;
            r_k        <= '0;
            r_chg_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rows_cfg <= n_rows_cfg;
            r_cols_cfg <= n_cols_cfg;
            r_vld      <= n_vld;
            r_rvld     <= n_rvld;
            r_out_vld  <= n_out_vld;
            r_rd       <= n_rd;
            r_k        <= n_k;
            r_chg_v    <= n_chg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_row0 <= n_row0;
        r_chg  <= n_chg;
        r_sum  <= n_sum;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Accesses to one row never overlap: a sweep writes each row after its last
    // read, and a cell write finishes before the next request is taken, so the
    // grid RAM needs no forwarding path.
    always_comb begin
        n_state    = r_state;
        n_rows_cfg = r_rows_cfg;
        n_cols_cfg = r_cols_cfg;
        n_vld      = r_vld;
        n_out_vld  = r_out_vld;
        n_rd       = r_rd;
        n_k        = r_k;
        n_chg_v    = r_chg_v;
        n_req      = r_req;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_row0     = r_row0;
        n_chg      = r_chg;
        n_sum      = r_sum;
        n_res      = r_res;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_req.row;
        ram_wdata  = rd_row;
        ram_raddr  = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS:    n_rows_cfg = i_cfg_data;
                CFG_COLUMNS: n_cols_cfg = i_cfg_data;
                default:     ;
            endcase
        end

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_req = i_req;
                    n_res = '0;
                    case (i_req.kind)
                        KIND_WRITE, KIND_READ: begin
                            if (bad) begin
                                n_res.bad_position = 1'b1;
                                n_state            = ST_PUSH;
                            end else begin
                                ram_raddr = i_req.row;
                                n_state   = ST_CELL;
                            end
                        end
                        KIND_STEP: begin
                            ram_raddr = ROW_AW'(nr - SIZE_W'(1));
                            n_state   = ST_G0;
                        end
                        default: n_state = ST_PUSH;
                    endcase
                end
            end
            ST_CELL: begin
                n_res = '0;
                if (r_req.kind == KIND_WRITE) begin
                    ram_wdata                 = rd_row;
                    ram_wdata[r_req.column]   = r_req.alive_in;
                    ram_we                    = 1'b1;
                    ram_waddr                 = r_req.row;
                end else begin
                    n_res.alive_out = rd_row[r_req.column];
                end
                n_state = ST_PUSH;
            end
            ST_G0: begin
                n_prev    = rd_row;
                ram_raddr = '0;
                n_rd      = SIZE_W'(1);
                n_state   = ST_G1;
            end
            ST_G1: begin
                n_cur     = rd_row;
                n_row0    = rd_row;
                ram_raddr = r_rd[ROW_AW-1:0];
                n_rd      = r_rd + SIZE_W'(1);
                n_k       = SIZE_W'(1);
                n_sum     = '0;
                n_chg_v   = 1'b0;
                n_state   = ST_SWEEP;
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = ROW_AW'(r_k - SIZE_W'(1));
                ram_wdata = new_row;
                n_chg     = new_row ^ r_cur;
                n_chg_v   = 1'b1;
                if (r_chg_v) begin
                    n_sum = r_sum + CHG_W'(pop_row(r_chg));
                end
                n_prev    = r_cur;
                n_cur     = nxt_row;
                // reads past the last row are issued but their data is unused
                ram_raddr = r_rd[ROW_AW-1:0];
                n_rd      = r_rd + SIZE_W'(1);
                n_k       = r_k + SIZE_W'(1);
                if (r_k == nr) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_res               = '0;
                n_res.changed_cells = r_sum + CHG_W'(pop_row(r_chg));
                n_chg_v             = 1'b0;
                n_state             = ST_PUSH;
            end
            ST_PUSH: begin
                if (!r_out_vld || i_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (ram_we) begin
            n_vld[ram_waddr] = 1'b1;
        end
        n_rvld = r_vld[ram_raddr];
    end

endmodule

>>> hw/rtl/tla_checker.sv
module tla_checker
    import tla_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_req i_req,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);

    // stalled response stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_rsp))
        else $error("response changed while stalled");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    // at most one result field is nonzero
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.bad_position && o_rsp.alive_out)
                 && !((o_rsp.bad_position || o_rsp.alive_out)
                      && (o_rsp.changed_cells != '0)))
        else $error("response fields overlap");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.changed_cells <= CHG_W'(MAX_ROWS * MAX_COLUMNS))
        else $error("changed count exceeds grid size");

endmodule

bind toroidal_life_automaton tla_checker u_tla_checker (.*);
